// ===== src/esfe_pkg.sv =====
// ----------------------------------------------------------------------------
// esfe_pkg - shared types and constants of the event stream frame encoder
// Holds the command word passed from the front end to the back end, the
// segment codes that make up one command and the character codes in use.
// ----------------------------------------------------------------------------
`default_nettype none

package esfe_pkg;

    // Character codes
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;

    // Item part codes
    localparam logic PART_EVENT = 1'b0;
    localparam logic PART_DATA  = 1'b1;

    // Widths
    localparam int LIMIT_W = 20;
    localparam int COUNT_W = 21;
    localparam int NUM_SEGS = 7;
    localparam int SEG_W = 3;

    // Segment codes, in emit order within one command
    localparam logic [SEG_W-1:0] SEG_LFA = 3'd0;  // LF closing an open event line
    localparam logic [SEG_W-1:0] SEG_EVP = 3'd1;  // "event: "
    localparam logic [SEG_W-1:0] SEG_DP1 = 3'd2;  // "data: " before the byte
    localparam logic [SEG_W-1:0] SEG_CHR = 3'd3;  // the byte itself
    localparam logic [SEG_W-1:0] SEG_LFB = 3'd4;  // LF closing the event line at its end
    localparam logic [SEG_W-1:0] SEG_DP2 = 3'd5;  // "data: " of the last line
    localparam logic [SEG_W-1:0] SEG_LFZ = 3'd6;  // LF LF closing the frame

    // One command: which segments to emit, the byte, and frame close
    typedef struct packed {
        logic [NUM_SEGS-1:0] segs;
        logic [7:0]          chr;
        logic                close;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/esfe_front.sv =====
// ----------------------------------------------------------------------------
// esfe_front - item classifier
// Tracks line state of the frame and turns each accepted item into one
// command word naming the segments that the back end must emit.
// ----------------------------------------------------------------------------
`default_nettype none

module esfe_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_part,
    input  wire logic          i_has_byte,
    input  wire logic [7:0]    i_char_in,
    input  wire logic          i_last_of_part,
    output esfe_pkg::t_cmd     o_cmd,
    output logic               o_cmd_wr
);
    import esfe_pkg::*;

    logic r_ev_open, n_ev_open;
    logic r_at_ls, n_at_ls;
    logic r_acr, n_acr;
    logic is_brk;
    logic open_now;
    logic ls_next;
    t_cmd cmd;

    // Classify the item and compute the next line state
    always_comb begin
        n_ev_open  = r_ev_open;
        n_at_ls    = r_at_ls;
        n_acr      = r_acr;
        cmd        = '0;
        is_brk     = (i_char_in == CH_CR) || (i_char_in == CH_LF);
        open_now   = r_ev_open | i_has_byte;
        ls_next    = r_at_ls;
        if (i_part == PART_EVENT) begin
            if (i_has_byte) begin
                cmd.segs[SEG_EVP] = !r_ev_open;
                cmd.segs[SEG_CHR] = 1'b1;
                cmd.chr           = is_brk ? CH_SP : i_char_in;
            end
            cmd.segs[SEG_LFB] = i_last_of_part & open_now;
            n_ev_open         = open_now & !i_last_of_part;
        end else begin
            // close a pending event line; its byte is dropped
            cmd.segs[SEG_LFA] = r_ev_open;
            n_ev_open         = 1'b0;
            if (i_has_byte && !r_ev_open) begin
                if (r_acr && (i_char_in == CH_LF)) begin
                    n_acr = 1'b0;
                end else begin
                    n_acr             = (i_char_in == CH_CR);
                    cmd.segs[SEG_DP1] = r_at_ls;
                    cmd.segs[SEG_CHR] = 1'b1;
                    cmd.chr           = is_brk ? CH_LF : i_char_in;
                    ls_next           = is_brk;
                end
            end
            n_at_ls = ls_next;
            if (i_last_of_part) begin
                cmd.segs[SEG_DP2] = ls_next;
                cmd.segs[SEG_LFZ] = 1'b1;
                cmd.close         = 1'b1;
                n_ev_open         = 1'b0;
                n_at_ls           = 1'b1;
                n_acr             = 1'b0;
            end
        end
    end

    // Hold line state between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_open <= 1'b0;
            r_at_ls   <= 1'b1;
            r_acr     <= 1'b0;
        end else if (i_accept) begin
            r_ev_open <= n_ev_open;
            r_at_ls   <= n_at_ls;
            r_acr     <= n_acr;
        end
    end

    // Drop commands that emit nothing and close nothing
    assign o_cmd    = cmd;
    assign o_cmd_wr = i_accept & ((|cmd.segs) | cmd.close);

endmodule

`default_nettype wire

// ===== src/esfe_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// esfe_cmd_queue - command queue
// Four-entry first-in first-out buffer of command words between the
// classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module esfe_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire esfe_pkg::t_cmd i_wdata,
    output logic               o_full,
    input  wire logic          i_rd,
    output esfe_pkg::t_cmd     o_rdata,
    output logic               o_empty
);
    import esfe_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    // Store incoming words
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/esfe_back.sv =====
// ----------------------------------------------------------------------------
// esfe_back - frame byte emitter
// Walks command segments, one byte a cycle into the consumer's buffer while
// it has room, counts frame bytes against the limit and aborts on overrun.
// ----------------------------------------------------------------------------
`default_nettype none

module esfe_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [esfe_pkg::LIMIT_W-1:0]  i_limit,
    input  wire esfe_pkg::t_cmd                i_cmd,
    input  wire logic                          i_cmd_empty,
    output logic                               o_cmd_rd,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic [7:0]                         o_out_byte,
    output logic                               o_frame_end,
    output logic                               o_error
);
    import esfe_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       fend;
        logic       err;
    } t_res;

    // Segment length in bytes
    function automatic logic [2:0] seg_len(input logic [SEG_W-1:0] seg);
        logic [2:0] len;
        unique case (seg)
            SEG_EVP:          len = 3'd7;
            SEG_DP1, SEG_DP2: len = 3'd6;
            SEG_LFZ:          len = 3'd2;
            default:          len = 3'd1;
        endcase
        return len;
    endfunction

    // Byte at position idx of a segment
    function automatic logic [7:0] seg_byte(input logic [SEG_W-1:0] seg,
                                            input logic [2:0] idx,
                                            input logic [7:0] chr);
        logic [7:0] b;
        b = CH_LF;
        unique case (seg)
            SEG_EVP: begin
                case (idx)
                    3'd0:    b = "e";
                    3'd1:    b = "v";
                    3'd2:    b = "e";
                    3'd3:    b = "n";
                    3'd4:    b = "t";
                    3'd5:    b = ":";
                    default: b = CH_SP;
                endcase
            end
            SEG_DP1, SEG_DP2: begin
                case (idx)
                    3'd0:    b = "d";
                    3'd1:    b = "a";
                    3'd2:    b = "t";
                    3'd3:    b = "a";
                    3'd4:    b = ":";
                    default: b = CH_SP;
                endcase
            end
            SEG_CHR: b = chr;
            default: b = CH_LF;
        endcase
        return b;
    endfunction

    // Current command
    logic                r_cur_valid;
    t_cmd                r_cur;
    logic [2:0]          r_idx;
    logic [COUNT_W-1:0]  r_count;
    logic                r_aborted;

    // Output buffer
    t_res                r_ob [2];
    logic                r_ob_wp;
    logic                r_ob_rp;
    logic [1:0]          r_ob_cnt;

    logic [SEG_W-1:0]    seg;
    logic                any_seg;
    logic [NUM_SEGS-1:0] rest;
    logic                seg_last;
    logic                cmd_last;
    logic                over;
    logic                skip;
    logic                emit;
    logic                done;
    logic                take;
    logic                ob_full;
    logic                ob_pop;
    t_res                res;

    // Pick the lowest pending segment
    always_comb begin
        seg = '0;
        for (int k = NUM_SEGS - 1; k >= 0; k--) begin
            if (r_cur.segs[k]) begin
                seg = SEG_W'(k);
            end
        end
    end

    always_comb begin
        any_seg  = |r_cur.segs;
        rest     = r_cur.segs & ~(NUM_SEGS'(1) << seg);
        seg_last = (r_idx == seg_len(seg) - 3'd1);
        cmd_last = seg_last && (rest == '0);
        over     = (r_count + COUNT_W'(1)) > {1'b0, i_limit};
        ob_full  = (r_ob_cnt == 2'd2);
        ob_pop   = i_pop && (r_ob_cnt != 2'd0);
        skip     = r_cur_valid && (r_aborted || !any_seg);
        emit     = r_cur_valid && !skip && !ob_full;
        done     = skip || (emit && (over || cmd_last));
        take     = !r_cur_valid || done;
        o_cmd_rd = take && !i_cmd_empty;
        if (over) begin
            res = '{data: 8'h00, fend: 1'b1, err: 1'b1};
        end else begin
            res = '{data: seg_byte(seg, r_idx, r_cur.chr),
                    fend: cmd_last && r_cur.close, err: 1'b0};
        end
    end

    // Load commands and advance through segments
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (take) begin
                r_cur_valid <= !i_cmd_empty;
                r_cur       <= i_cmd;
                r_idx       <= '0;
            end else if (emit) begin
                if (seg_last) begin
                    r_cur.segs <= rest;
                    r_idx      <= '0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    // Count frame bytes; abort on overrun; clear when the frame closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_aborted <= 1'b0;
        end else if (done && r_cur.close) begin
            r_count   <= '0;
            r_aborted <= 1'b0;
        end else if (emit) begin
            if (over) begin
                r_aborted <= 1'b1;
            end else begin
                r_count <= r_count + COUNT_W'(1);
            end
        end
    end

    // Buffer result words
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ob[r_ob_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= '0;
        end else begin
            if (emit) begin
                r_ob_wp <= !r_ob_wp;
            end
            if (ob_pop) begin
                r_ob_rp <= !r_ob_rp;
            end
            if (emit && !ob_pop) begin
                r_ob_cnt <= r_ob_cnt + 2'd1;
            end else if (!emit && ob_pop) begin
                r_ob_cnt <= r_ob_cnt - 2'd1;
            end
        end
    end

    assign o_empty     = (r_ob_cnt == 2'd0);
    assign o_out_byte  = r_ob[r_ob_rp].data;
    assign o_frame_end = r_ob[r_ob_rp].fend;
    assign o_error     = r_ob[r_ob_rp].err;

endmodule

`default_nettype wire

// ===== src/event_stream_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// event_stream_frame_encoder - server-sent-events frame encoder
// Encodes an event name and data payload, one byte per word, into an event
// stream frame, one byte per result word, with a frame length limit.
// ----------------------------------------------------------------------------
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   input    | push / full               | i_part i_has_byte i_char_in
//            |                           | i_last_of_part
//   result   | pop / empty               | o_out_byte o_frame_end o_error
//   config   | i_cfg_valid / o_cfg_ready | i_max_frame_bytes
//
// The classifier takes one word per cycle while the command queue has room.
// The emitter produces one result byte per cycle while the output buffer has
// room; a word causes up to 15 bytes, a word that causes nothing is dropped at
// once, and one that comes after an abort yields no byte. Reset is
// synchronous; it clears line state, the byte count, the queues and sets the
// limit to 65536. A stalled consumer fills the two-word output buffer, the
// emitter's current command and then the command queue before full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module event_stream_frame_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_part,
    input  wire logic        i_has_byte,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_last_of_part,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_frame_end,
    output logic             o_error,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [19:0] i_max_frame_bytes
);
    import esfe_pkg::*;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd65536;

    logic [LIMIT_W-1:0] r_limit;
    logic               accept;
    t_cmd               front_cmd;
    logic               front_wr;
    logic               q_full;
    logic               q_empty;
    logic               q_rd;
    t_cmd               q_cmd;

    // Hold the frame length limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_max_frame_bytes;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    esfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_part         (i_part),
        .i_has_byte     (i_has_byte),
        .i_char_in      (i_char_in),
        .i_last_of_part (i_last_of_part),
        .o_cmd          (front_cmd),
        .o_cmd_wr       (front_wr)
    );

    esfe_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_wdata (front_cmd),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_cmd),
        .o_empty (q_empty)
    );

    esfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_rd    (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_error     (o_error)
    );

    // An abort word always ends the frame
    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_frame_end && (o_out_byte == 8'h00)))
        else $error("abort word without frame end");

    // A regular frame ends on a line feed
    a_end_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end && !o_error) |-> (o_out_byte == CH_LF))
        else $error("frame ends on a byte other than LF");

    // The classifier never writes into a full queue
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_wr |-> !q_full)
        else $error("command queue overflow");

    // A command is read only when one is waiting
    a_no_udf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !q_empty)
        else $error("command queue underflow");

endmodule

`default_nettype wire

// ===== dv/tb_event_stream_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_event_stream_frame_encoder - self-checking bench of the frame encoder
// Pushes event name and data words in random bursts and pops encoded frame
// bytes under a changing stall pattern. A scoreboard encodes every accepted
// word on its own and compares each popped byte with the oldest prediction,
// over several frame length limits from zero to the largest.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_event_stream_frame_encoder;

    import esfe_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam logic [19:0] LIMIT_RESET = 20'd65536;
    localparam logic [19:0] LIMIT_MAX   = 20'hFFFFF;

    // ------------------------------------------------------------------------
    // Frame scoreboard: own copy of line state, byte count and limit
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        typedef struct {
            logic [7:0] code;
            logic       frame_end;
            logic       error;
        } t_frame_out;

        t_frame_out  expected[$];
        logic [19:0] limit;
        logic [20:0] frame_count;
        bit          event_open;
        bit          at_start;
        bit          after_cr;
        bit          aborted;
        bit          step_halted;
        int          step_outs;
        int          errors;
        int          sent_words;

        function new();
            limit      = LIMIT_RESET;
            errors     = 0;
            sent_words = 0;
            clear_frame();
        endfunction

        function void set_limit(logic [19:0] value);
            limit = value;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void clear_frame();
            event_open  = 1'b0;
            at_start    = 1'b1;
            after_cr    = 1'b0;
            frame_count = '0;
            aborted     = 1'b0;
        endfunction

        // Emit one byte, or the error result when the limit would be passed
        function void emit(logic [7:0] c);
            t_frame_out r;
            if (step_halted || step_outs >= 15) return;
            if (frame_count + 21'd1 > {1'b0, limit}) begin
                r = '{code: 8'h00, frame_end: 1'b1, error: 1'b1};
                expected.insert(expected.size(), r);
                step_outs++;
                step_halted = 1'b1;
                aborted     = 1'b1;
                return;
            end
            frame_count++;
            r = '{code: c, frame_end: 1'b0, error: 1'b0};
            expected.insert(expected.size(), r);
            step_outs++;
        endfunction

        function void emit_text(string s);
            for (int i = 0; i < s.len(); i++) emit(s[i]);
        endfunction

        // Encode one accepted word
        function void note_word(logic part, logic has, logic [7:0] c, logic last);
            bit take;
            step_halted = 1'b0;
            step_outs   = 0;
            sent_words++;
            if (aborted) begin
                if (part == PART_DATA && last) clear_frame();
                return;
            end
            if (part == PART_EVENT) begin
                if (has) begin
                    if (!event_open) begin
                        emit_text("event: ");
                        event_open = 1'b1;
                    end
                    emit((c == CH_CR || c == CH_LF) ? CH_SP : c);
                end
                if (last && event_open) begin
                    emit(CH_LF);
                    event_open = 1'b0;
                end
                return;
            end
            // Close an open event line; the byte of this word is dropped
            take = has;
            if (event_open) begin
                emit(CH_LF);
                event_open = 1'b0;
                take       = 1'b0;
            end
            if (take) begin
                if (after_cr && c == CH_LF) begin
                    after_cr = 1'b0;
                end else begin
                    after_cr = 1'b0;
                    if (c == CH_CR || c == CH_LF) begin
                        if (at_start) emit_text("data: ");
                        emit(CH_LF);
                        at_start = 1'b1;
                        after_cr = (c == CH_CR);
                    end else begin
                        if (at_start) begin
                            emit_text("data: ");
                            at_start = 1'b0;
                        end
                        emit(c);
                    end
                end
            end
            // Close the frame: last data line, then the empty line
            if (last) begin
                if (at_start) emit_text("data: ");
                emit(CH_LF);
                emit(CH_LF);
                if (!step_halted && step_outs > 0)
                    expected[expected.size()-1].frame_end = 1'b1;
                clear_frame();
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(logic [7:0] code, logic frame_end, logic error);
            t_frame_out e;
            if (expected.size() == 0) begin
                report($sformatf("unexpected word byte=%h end=%b err=%b",
                                 code, frame_end, error));
                return;
            end
            e = expected[0];
            expected.delete(0);
            if (error !== e.error || frame_end !== e.frame_end ||
                (!e.error && code !== e.code))
                report($sformatf("got byte=%h end=%b err=%b, want byte=%h end=%b err=%b",
                                 code, frame_end, error, e.code, e.frame_end, e.error));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    typedef struct {
        logic       part;
        logic       has;
        logic [7:0] chr;
        logic       last;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_part;
    logic        i_has_byte;
    logic [7:0]  i_char_in;
    logic        i_last_of_part;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_frame_end;
    logic        o_error;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [19:0] i_max_frame_bytes;

    frame_scoreboard sb;
    t_word           word_queue[$];
    int              burst_left;
    bit              hold_req;
    int              hold_left;
    int              pop_mode;
    int              pop_mode_left;
    int              pop_cycle;

    event_stream_frame_encoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_part            (i_part),
        .i_has_byte        (i_has_byte),
        .i_char_in         (i_char_in),
        .i_last_of_part    (i_last_of_part),
        .empty             (empty),
        .pop               (pop),
        .o_out_byte        (o_out_byte),
        .o_frame_end       (o_frame_end),
        .o_error           (o_error),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_max_frame_bytes (i_max_frame_bytes)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    task automatic add_word(logic part, logic has, logic [7:0] c, logic last);
        t_word w;
        w = '{part: part, has: has, chr: c, last: last};
        word_queue.insert(word_queue.size(), w);
    endtask

    // Push all queued words in bursts; push may stay high after the last word
    task automatic send_words();
        t_word w;
        bit    ok;
        int    gap;
        while (word_queue.size() > 0) begin
            w = word_queue[0];
            word_queue.delete(0);
            push           <= 1'b1;
            i_part         <= w.part;
            i_has_byte     <= w.has;
            i_char_in      <= w.chr;
            i_last_of_part <= w.last;
            do begin
                @(negedge i_clk);
                ok = !full;
                @(posedge i_clk);
            end while (!ok);
            sb.note_word(w.part, w.has, w.chr, w.last);
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = ($urandom % 5 == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
                gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    // Wait for every expected word, then for words that cause no output
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [19:0] value);
        bit ok;
        i_cfg_valid       <= 1'b1;
        i_max_frame_bytes <= value;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
        sb.set_limit(value);
    endtask

    function automatic logic [7:0] rand_char(int break_pct);
        if ($urandom % 100 < break_pct)
            return ($urandom % 2) ? CH_CR : CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one frame: mostly well formed, sometimes noise closed by a data last
    task automatic gen_frame();
        int kind;
        int name_len;
        int data_len;
        int n;
        kind = $urandom % 10;
        if (kind < 8) begin
            name_len = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
            if (name_len == 0) begin
                if ($urandom % 2) add_word(PART_EVENT, 1'b0, rand_char(0), 1'b1);
            end else begin
                for (int i = 0; i < name_len; i++)
                    add_word(PART_EVENT, ($urandom % 10 != 0), rand_char(15),
                             (i == name_len - 1));
            end
            data_len = ($urandom % 8 == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < data_len; i++)
                add_word(PART_DATA, ($urandom % 12 != 0), rand_char(25), (i == data_len - 1));
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                add_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         rand_char(20), 1'($urandom_range(0, 1)));
            add_word(PART_DATA, 1'($urandom_range(0, 1)), rand_char(20), 1'b1);
        end
    endtask

    // Set the limit, then send random frames until enough words were sent
    task automatic run_phase(logic [19:0] limit, int target, bit hold);
        int start;
        start = sb.sent_words;
        write_limit(limit);
        if (hold) hold_req = 1'b1;
        while (sb.sent_words - start < target) begin
            gen_frame();
            send_words();
        end
        push <= 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall pattern, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        pop           = 1'b0;
        hold_left     = 0;
        pop_mode      = 0;
        pop_mode_left = 0;
        pop_cycle     = 0;
        forever begin
            @(posedge i_clk);
            pop_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end else begin
                if (pop_mode_left <= 0) begin
                    pop_mode      = $urandom_range(0, 4);
                    pop_mode_left = $urandom_range(16, 128);
                end
                pop_mode_left--;
                case (pop_mode)
                    0: begin
                        pop <= 1'b1;
                    end
                    1: begin
                        pop <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        pop <= ($urandom % 10 != 0);
                    end
                    3: begin
                        pop <= (pop_cycle % 8 < 3);
                    end
                    default: begin
                        pop <= ($urandom % 5 == 0);
                    end
                endcase
            end
        end
    end

    // Check each word that the next edge will take
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && pop && empty === 1'b0)
            sb.check_result(o_out_byte, o_frame_end, o_error);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        push              = 1'b0;
        i_part            = 1'b0;
        i_has_byte        = 1'b0;
        i_char_in         = 8'h00;
        i_last_of_part    = 1'b0;
        i_cfg_valid       = 1'b0;
        i_max_frame_bytes = '0;
        hold_req          = 1'b0;
        burst_left        = 0;
        sb                = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Event name with CR, LF and a high byte, under the reset limit
        add_word(PART_EVENT, 1'b1, 8'h41, 1'b0);
        add_word(PART_EVENT, 1'b1, CH_CR, 1'b0);
        add_word(PART_EVENT, 1'b1, CH_LF, 1'b0);
        add_word(PART_EVENT, 1'b1, 8'hFF, 1'b1);
        // Empty name, then data with CRLF, an empty line and a trailing break
        add_word(PART_EVENT, 1'b0, 8'hFF, 1'b1);
        add_word(PART_DATA, 1'b1, 8'h00, 1'b0);
        add_word(PART_DATA, 1'b1, 8'h7F, 1'b0);
        add_word(PART_DATA, 1'b1, CH_CR, 1'b0);
        add_word(PART_DATA, 1'b1, CH_LF, 1'b0);
        add_word(PART_DATA, 1'b1, CH_LF, 1'b0);
        add_word(PART_DATA, 1'b0, 8'h55, 1'b0);
        add_word(PART_DATA, 1'b1, 8'h78, 1'b0);
        add_word(PART_DATA, 1'b1, CH_CR, 1'b1);
        // Empty event name and empty data
        add_word(PART_EVENT, 1'b0, 8'h00, 1'b0);
        add_word(PART_DATA, 1'b0, 8'hAA, 1'b1);
        // Data word while the event line is still open
        add_word(PART_EVENT, 1'b1, 8'h71, 1'b0);
        add_word(PART_DATA, 1'b1, 8'h7A, 1'b1);
        // Event word in the middle of data
        add_word(PART_DATA, 1'b1, 8'h61, 1'b0);
        add_word(PART_EVENT, 1'b1, 8'h62, 1'b1);
        add_word(PART_DATA, 1'b1, CH_LF, 1'b1);
        send_words();
        push <= 1'b0;
        wait_drained();

        // Limit met exactly by the event line, passed by the first data byte
        write_limit(20'd9);
        add_word(PART_EVENT, 1'b1, 8'h6E, 1'b1);
        add_word(PART_DATA, 1'b1, 8'h61, 1'b0);
        add_word(PART_DATA, 1'b1, 8'h62, 1'b0);
        add_word(PART_EVENT, 1'b1, 8'h63, 1'b1);
        add_word(PART_DATA, 1'b1, 8'h64, 1'b1);
        send_words();
        push <= 1'b0;
        wait_drained();

        // Zero limit: the abort lands on the frame's last word
        write_limit(20'd0);
        add_word(PART_DATA, 1'b0, 8'h00, 1'b1);
        send_words();
        push <= 1'b0;
        wait_drained();

        // Random frames over several limits; the first phase fills the block
        run_phase(LIMIT_MAX, 80, 1'b1);
        run_phase(20'd0, 30, 1'b0);
        run_phase(20'($urandom_range(8, 40)), 60, 1'b0);
        run_phase(LIMIT_RESET, 80, 1'b0);
        run_phase(20'($urandom_range(0, 1048575)), 50, 1'b0);
        run_phase(20'($urandom_range(40, 120)), 60, 1'b0);
        run_phase(20'($urandom_range(1, 16)), 50, 1'b0);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_event_stream_frame_encoder: clean");
        end else begin
            $display("tb_event_stream_frame_encoder: errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("tb_event_stream_frame_encoder: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/esfe_pkg.sv
src/esfe_front.sv
src/esfe_cmd_queue.sv
src/esfe_back.sv
src/event_stream_frame_encoder.sv
dv/tb_event_stream_frame_encoder.sv
